>>> hdl/lfu_pkg.sv
// Shared sizes and constants for the LFU cache table.
package lfu_pkg;

  // Table geometry
  localparam int CAPACITY    = 16;
  localparam int COUNT_WIDTH = 16;

  // Derived widths
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int CFG_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Configuration reset value
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  // Operation codes
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

endpackage

>>> hdl/lfu_cache_table.sv
// Fully associative key/value table with LFU replacement and LRU tie-break.
// Sequence: entry scan over every entry, a decide step, an update step, then
//   the output load; the update step is skipped when no table update is
//   needed (get miss, put at zero capacity).
// A new input word is taken only once the last result word has loaded, so a
//   stalled result word holds off the next input.
// Reset (rst, synchronous): table empty, active_capacity back to 16,
//   no result pending.
module lfu_cache_table
  import lfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  // input words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value_in,
  // result words
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic [VAL_W-1:0] value_out,
  output logic             evicted
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_TOUCH,
    S_INSERT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [CFG_W-1:0] active_capacity;

  // Table storage
  logic [CAPACITY-1:0]    entry_valid;
  logic [KEY_W-1:0]       entry_key    [CAPACITY];
  logic [VAL_W-1:0]       entry_value  [CAPACITY];
  logic [COUNT_WIDTH-1:0] use_count    [CAPACITY];
  logic [IDX_W-1:0]       recency_rank [CAPACITY];
  logic [FILL_W-1:0]      fill_count;

  // Current operation
  logic             op_func;
  logic [KEY_W-1:0] op_key;
  logic [VAL_W-1:0] op_value;

  // Scan pointer and scan results
  logic                   [IDX_W-1:0] idx;
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic                   have_victim;
  logic [IDX_W-1:0]       vic_idx;
  logic [COUNT_WIDTH-1:0] best_cnt;
  logic [IDX_W-1:0]       best_rank;
  logic                   have_free;
  logic [IDX_W-1:0]       free_idx;

  // Pending result
  logic             r_hit;
  logic [VAL_W-1:0] r_value;
  logic             r_evicted;

  // Shared signals: entry fields and compares at the pointer idx, clamped capacity, output free
  logic                   cur_valid;
  logic [KEY_W-1:0]       cur_key;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [IDX_W-1:0]       cur_rank;
  logic                   key_match;
  logic                   better_victim;
  logic                   scan_last;
  logic [FILL_W-1:0]      cap_eff;
  logic                   out_free;

  assign cur_valid = entry_valid[idx];
  assign cur_key   = entry_key[idx];
  assign cur_cnt   = use_count[idx];
  assign cur_rank  = recency_rank[idx];
  assign key_match = cur_valid && (cur_key == op_key);
  assign better_victim = cur_valid &&
                         (!have_victim || (cur_cnt < best_cnt) ||
                          ((cur_cnt == best_cnt) && (cur_rank > best_rank)));
  assign scan_last = (idx == IDX_W'(CAPACITY - 1));
  assign out_free  = !out_valid || !out_stall;

  // Clamp capacity to the table size
  always_comb begin
    if (32'(active_capacity) > 32'(CAPACITY)) begin
      cap_eff = FILL_W'(CAPACITY);
    end else begin
      cap_eff = FILL_W'(active_capacity);
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer, table updates and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      active_capacity <= CAP_RESET;
      entry_valid     <= '0;
      fill_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        active_capacity <= cfg_data;
      end

      // Drop the result word once taken, unless a new one loads now
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_func     <= func;
            op_key      <= key;
            op_value    <= value_in;
            idx         <= '0;
            hit_found   <= 1'b0;
            have_victim <= 1'b0;
            have_free   <= 1'b0;
            r_hit       <= 1'b0;
            r_value     <= '0;
            r_evicted   <= 1'b0;
            state       <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Look for key, victim and first free slot, one entry a cycle
          if (key_match && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (better_victim) begin
            have_victim <= 1'b1;
            vic_idx     <= idx;
            best_cnt    <= cur_cnt;
            best_rank   <= cur_rank;
          end
          if (!cur_valid && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          if (scan_last) begin
            state <= S_DECIDE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        S_DECIDE: begin
          priority if (op_func == FUNC_GET) begin
            if (hit_found) begin
              r_hit <= 1'b1;
              idx   <= hit_idx;
              state <= S_TOUCH;
            end else begin
              state <= S_DONE;
            end
          end else if (cap_eff == '0) begin
            state <= S_DONE;
          end else if (hit_found) begin
            r_hit <= 1'b1;
            idx   <= hit_idx;
            state <= S_TOUCH;
          end else if ((fill_count >= cap_eff) && have_victim) begin
            r_evicted <= 1'b1;
            idx       <= vic_idx;
            state     <= S_INSERT;
          end else if (have_free) begin
            idx   <= free_idx;
            state <= S_INSERT;
          end else begin
            state <= S_DONE;
          end
        end

        S_TOUCH: begin
          // Age the more recent entries, make this one most recent
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_valid[i] && (IDX_W'(i) != idx) && (recency_rank[i] < cur_rank)) begin
              recency_rank[i] <= recency_rank[i] + IDX_W'(1);
            end
          end
          recency_rank[idx] <= '0;
          if (cur_cnt != '1) begin
            use_count[idx] <= cur_cnt + COUNT_WIDTH'(1);
          end
          if (op_func == FUNC_GET) begin
            r_value <= entry_value[idx];
          end else begin
            entry_value[idx] <= op_value;
          end
          state <= S_DONE;
        end

        S_INSERT: begin
          // Entries older than the victim hold, all others age by one
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_valid[i] && (IDX_W'(i) != idx) &&
                !(r_evicted && (recency_rank[i] > best_rank))) begin
              recency_rank[i] <= recency_rank[i] + IDX_W'(1);
            end
          end
          entry_valid[idx]  <= 1'b1;
          entry_key[idx]    <= op_key;
          entry_value[idx]  <= op_value;
          use_count[idx]    <= COUNT_WIDTH'(1);
          recency_rank[idx] <= '0;
          if (!r_evicted) begin
            fill_count <= fill_count + FILL_W'(1);
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // Load the result word when the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            hit       <= r_hit;
            value_out <= r_value;
            evicted   <= r_evicted;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill count tracks the valid bits
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) == $countones(entry_valid))
    else $error("fill_count does not match number of valid entries");

  // Table never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= CAPACITY)
    else $error("fill_count above table size");

  // An eviction result is always a put miss with zero value
  a_evict_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (!hit && (value_out == '0)))
    else $error("evicted result carries hit or value");

  // Accepting a word closes the input until the item finishes
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item in flight");

endmodule

>>> verif/tb_lfu_cache_table.sv
// Self-checking testbench for the LFU cache table: directed table, then random put/get traffic.
module tb_lfu_cache_table;
  import lfu_pkg::*;

  // Run control
  localparam int RESET_CYCLES  = 11;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_ITEMS   = 82;
  localparam int POOL_SIZE     = 32;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int STEADY_FROM   = 520;
  localparam int STEADY_TO     = 680;
  localparam int IDLE_PCT      = 38;
  localparam int MAX_PRINTS    = 100;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             evicted;
  } cache_resp_t;

  typedef enum logic [1:0] {ROW_PRED, ROW_FIXED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    cache_resp_t      want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value_in;
  logic             out_valid;
  logic             out_stall;
  logic             hit;
  logic [VAL_W-1:0] value_out;
  logic             evicted;

  lfu_cache_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .key       (key),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .value_out (value_out),
    .evicted   (evicted)
  );

  // Shadow copy of the table
  logic [CFG_W-1:0]       m_cap;
  logic                   m_valid [CAPACITY];
  logic [KEY_W-1:0]       m_key   [CAPACITY];
  logic [VAL_W-1:0]       m_value [CAPACITY];
  logic [COUNT_WIDTH-1:0] m_count [CAPACITY];
  logic [IDX_W-1:0]       m_rank  [CAPACITY];
  int                     m_fill;

  cache_resp_t      pending_results [$];
  cache_resp_t      want_r;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               error_count = 0;
  int               cycle_count = 0;
  int               n_sent = 0;
  int               hold_left = 0;
  logic             hold_done = 1'b0;

  // Directed stimulus; ROW_CFG carries the capacity in the v column
  localparam int PLAN_LEN = 29;
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_FIXED, FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{ROW_FIXED, FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF, '{1'b1, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'h0000_0000, 32'h1234_5678, '{1'b1, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b1, 32'h1234_5678, 1'b0}},
    // zero capacity: puts ignored, gets still look up
    '{ROW_CFG,   FUNC_PUT, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'h0000_0005, 32'h0000_0077, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'h0000_0000, 32'h0000_0009, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_GET, 32'h0000_0005, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    // capacity lowered below the fill level
    '{ROW_CFG,   FUNC_PUT, 32'h0000_0000, 32'h0000_0001, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_FIXED, FUNC_PUT, 32'hA5A5_A5A5, 32'h0000_0001, '{1'b0, 32'h0000_0000, 1'b1}},
    '{ROW_PRED,  FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h5A5A_5A5A, 32'h0000_0002, '{1'b0, 32'h0000_0000, 1'b0}},
    // small table: count and recency tie-break on eviction
    '{ROW_CFG,   FUNC_PUT, 32'h0000_0000, 32'h0000_0002, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0011, 32'h0000_0003, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_GET, 32'h5A5A_5A5A, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0022, 32'h0000_0004, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0033, 32'h0000_0005, '{1'b0, 32'h0000_0000, 1'b0}},
    // capacity above the table size
    '{ROW_CFG,   FUNC_PUT, 32'h0000_0000, 32'h0000_001F, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0044, 32'h0000_0006, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0055, 32'h0000_0007, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_GET, 32'h0000_0033, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_GET, 32'h0000_0044, 32'h0000_0000, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_PRED,  FUNC_PUT, 32'h0000_0033, 32'h0000_0008, '{1'b0, 32'h0000_0000, 1'b0}},
    '{ROW_CFG,   FUNC_PUT, 32'h0000_0000, 32'h0000_0010, '{1'b0, 32'h0000_0000, 1'b0}}
  };

  // Free-running clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic steady_window();
    return (n_sent >= STEADY_FROM) && (n_sent < STEADY_TO);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // Make entry e the most recent and raise its count
  function automatic void promote_entry(int e);
    int i;
    for (i = 0; i < CAPACITY; i++)
      if (m_valid[i] && i != e && m_rank[i] < m_rank[e]) m_rank[i]++;
    m_rank[e] = '0;
    if (m_count[e] != COUNT_MAX) m_count[e]++;
  endfunction

  // Apply one put or get to the shadow table and return its result word
  function automatic cache_resp_t predict_access(logic op, logic [KEY_W-1:0] k,
                                                 logic [VAL_W-1:0] v);
    cache_resp_t r;
    int i, e, slot, cap;
    r = '0;
    cap = (m_cap > CAPACITY) ? CAPACITY : int'(m_cap);
    e = -1;
    for (i = 0; i < CAPACITY; i++)
      if (e < 0 && m_valid[i] && m_key[i] == k) e = i;

    if (op == FUNC_GET) begin
      if (e >= 0) begin
        r.hit = 1'b1;
        r.value = m_value[e];
        promote_entry(e);
      end
      return r;
    end

    if (cap == 0) return r;

    if (e >= 0) begin
      r.hit = 1'b1;
      m_value[e] = v;
      promote_entry(e);
      return r;
    end

    // Evict lowest count, oldest among ties
    slot = -1;
    if (m_fill >= cap) begin
      for (i = 0; i < CAPACITY; i++) begin
        if (m_valid[i]) begin
          if (slot < 0) slot = i;
          else if (m_count[i] < m_count[slot]) slot = i;
          else if (m_count[i] == m_count[slot] && m_rank[i] > m_rank[slot]) slot = i;
        end
      end
      if (slot >= 0) begin
        m_valid[slot] = 1'b0;
        for (i = 0; i < CAPACITY; i++)
          if (m_valid[i] && m_rank[i] > m_rank[slot]) m_rank[i]--;
        m_fill--;
        r.evicted = 1'b1;
      end
    end
    if (slot < 0) begin
      for (i = CAPACITY - 1; i >= 0; i--)
        if (!m_valid[i]) slot = i;
      if (slot < 0) return r;
    end

    // Insert as most recent with count one
    for (i = 0; i < CAPACITY; i++)
      if (m_valid[i]) m_rank[i]++;
    m_valid[slot] = 1'b1;
    m_key[slot]   = k;
    m_value[slot] = v;
    m_count[slot] = COUNT_WIDTH'(1);
    m_rank[slot]  = '0;
    m_fill++;
    return r;
  endfunction

  // Offer one input word and record its expected result once accepted
  task automatic send_op(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                         logic fixed, cache_resp_t want);
    cache_resp_t pred;
    @(negedge clk);
    while (!steady_window() && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    value_in <= v;
    do @(posedge clk); while (in_stall);
    pred = predict_access(op, k, v);
    pending_results.push_back(fixed ? want : pred);
    n_sent++;
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    m_cap = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic over a small key pool so that hits and evictions are frequent
  task automatic run_random_phase(logic [CFG_W-1:0] cap, int n);
    int j, eff, span;
    logic op;
    logic [KEY_W-1:0] k;
    write_capacity(cap);
    eff  = (cap > CAPACITY) ? CAPACITY : int'(cap);
    span = (eff + 3 > POOL_SIZE - 1) ? POOL_SIZE - 1 : eff + 3;
    for (j = 0; j < n; j++) begin
      op = ($urandom_range(99) < 55) ? FUNC_PUT : FUNC_GET;
      if ($urandom_range(99) < 8) k = $urandom;
      else k = key_pool[$urandom_range(span, 0)];
      send_op(op, k, $urandom, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, one long hold-off, and a steady window
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, hit}, 32'd0);
      end else begin
        want_r = pending_results.pop_front();
        if (hit !== want_r.hit) report_mismatch("hit", {31'd0, hit}, {31'd0, want_r.hit});
        if (value_out !== want_r.value) report_mismatch("value_out", value_out, want_r.value);
        if (evicted !== want_r.evicted)
          report_mismatch("evicted", {31'd0, evicted}, {31'd0, want_r.evicted});
      end
    end
  end

  // Main sequence
  initial begin
    int r, p;
    logic [CFG_W-1:0] phase_caps [11];
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    func      = FUNC_PUT;
    key       = '0;
    value_in  = '0;
    m_cap     = CAP_RESET;
    m_fill    = 0;
    for (r = 0; r < CAPACITY; r++) begin
      m_valid[r] = 1'b0;
      m_key[r]   = '0;
      m_value[r] = '0;
      m_count[r] = '0;
      m_rank[r]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (r = 0; r < PLAN_LEN; r++) begin
      case (plan[r].kind)
        ROW_CFG: begin
          write_capacity(plan[r].v[CFG_W-1:0]);
        end
        ROW_FIXED: begin
          send_op(plan[r].op, plan[r].k, plan[r].v, 1'b1, plan[r].want);
        end
        default: begin
          send_op(plan[r].op, plan[r].k, plan[r].v, 1'b0, '0);
        end
      endcase
    end

    // Random phases across several capacities, extremes included
    for (r = 0; r < POOL_SIZE; r++) key_pool[r] = $urandom;
    phase_caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd17, 5'd0, 5'd2, 5'd8, 5'd0, 5'd16};
    phase_caps[6] = CFG_W'($urandom_range(31, 0));
    phase_caps[9] = CFG_W'($urandom_range(31, 0));
    for (p = 0; p < 11; p++) run_random_phase(phase_caps[p], PHASE_ITEMS);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("missing words", pending_results.size(), 32'd0);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
